// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/aat_pkg.sv =====
// Shared types, constants and helper functions of the box transform block.
package aat_pkg;

  localparam int unsigned CoordW     = 32;
  localparam int unsigned FracW      = 16;
  localparam int unsigned ProdW      = 2 * CoordW;
  localparam int unsigned AccW       = ProdW + 2;
  localparam int unsigned NumAxes    = 3;
  localparam int unsigned NumRows    = 3;
  localparam int unsigned NumCols    = 4;
  localparam int unsigned NumCorners = 8;
  localparam int unsigned CornerW    = $clog2(NumCorners);
  localparam int unsigned RowW       = $clog2(NumRows);
  localparam int unsigned CmdW       = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [AccW-1:0]   acc_t;

  localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef enum logic [CmdW-1:0] {
    CMD_RESET     = 3'd0,
    CMD_GROW_MIN  = 3'd1,
    CMD_GROW_MAX  = 3'd2,
    CMD_LOAD_ROW  = 3'd3,
    CMD_TRANSFORM = 3'd4,
    CMD_REPORT    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CORNER,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    coord_t          point_x;
    coord_t          point_y;
    coord_t          point_z;
    logic [1:0]      row_index;
    coord_t          coef_0;
    coord_t          coef_1;
    coord_t          coef_2;
    coord_t          coef_3;
  } in_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    coord_t half_x;
    coord_t half_y;
    coord_t half_z;
  } out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic               accept;
    logic               corner_en;
    logic [CornerW-1:0] corner_idx;
    logic               emit;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pipe_busy;
  } dp_stat_t;

  // floor((a + b) / 2) from the exact sum.
  function automatic coord_t half_sum(coord_t a, coord_t b);
    logic signed [CoordW:0] s;
    s = {a[CoordW-1], a} + {b[CoordW-1], b};
    return s[CoordW:1];
  endfunction

  // floor((a - b) / 2) from the exact difference.
  function automatic coord_t half_diff(coord_t a, coord_t b);
    logic signed [CoordW:0] s;
    s = {a[CoordW-1], a} - {b[CoordW-1], b};
    return s[CoordW:1];
  endfunction

endpackage

// ===== rtl/core/aat_ctrl.sv =====
// Sequencer: input and output handshake, corner issue and pipeline drain.
module aat_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [aat_pkg::CmdW-1:0] in_cmd_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  aat_pkg::dp_stat_t     stat_i,
  output aat_pkg::ctrl_cmd_t    cmd_o
);

  aat_pkg::ctrl_state_e state_q, state_d;
  logic [aat_pkg::CornerW-1:0] cnt_q, cnt_d;
  logic out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= aat_pkg::ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    out_vld_d        = out_vld_q && out_stall_i;
    cmd_o            = '0;
    cmd_o.corner_idx = cnt_q;
    in_stall_o       = 1'b1;
    case (state_q)
      aat_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          if (in_cmd_i == aat_pkg::CMD_TRANSFORM) begin
            state_d = aat_pkg::ST_CORNER;
          end else begin
            state_d = aat_pkg::ST_EMIT;
          end
        end
      end
      aat_pkg::ST_CORNER: begin
        cmd_o.corner_en = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == aat_pkg::CornerW'(aat_pkg::NumCorners - 1)) begin
          state_d = aat_pkg::ST_DRAIN;
        end
      end
      aat_pkg::ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = aat_pkg::ST_EMIT;
        end
      end
      aat_pkg::ST_EMIT: begin
        // hold until the output register is free or drains this cycle
        if (!out_vld_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          out_vld_d  = 1'b1;
          state_d    = aat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aat_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_vld_q;

endmodule

// ===== rtl/core/aat_dp.sv =====
// Datapath: box and matrix state, corner multiply pipeline, output register.
module aat_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aat_pkg::in_t       in_data_i,
  input  aat_pkg::ctrl_cmd_t cmd_i,
  output aat_pkg::dp_stat_t  stat_o,
  output aat_pkg::out_t      out_data_o
);

  aat_pkg::coord_t cur_min_q  [aat_pkg::NumAxes];
  aat_pkg::coord_t cur_max_q  [aat_pkg::NumAxes];
  aat_pkg::coord_t orig_min_q [aat_pkg::NumAxes];
  aat_pkg::coord_t orig_max_q [aat_pkg::NumAxes];
  logic            has_orig_q;
  aat_pkg::coord_t matrix_q   [aat_pkg::NumRows][aat_pkg::NumCols];
  logic [aat_pkg::CmdW-1:0] cmd_q;

  aat_pkg::coord_t pt     [aat_pkg::NumAxes];
  aat_pkg::coord_t coef   [aat_pkg::NumCols];
  aat_pkg::coord_t corner [aat_pkg::NumAxes];

  // multiply pipeline: products, sum, saturated value
  logic            p_vld_q, s_vld_q, v_vld_q;
  aat_pkg::prod_t  prod_q [aat_pkg::NumRows][aat_pkg::NumAxes];
  aat_pkg::coord_t tr_q   [aat_pkg::NumRows];
  aat_pkg::acc_t   sum_q  [aat_pkg::NumRows];
  aat_pkg::coord_t sat_q  [aat_pkg::NumRows];

  aat_pkg::out_t   out_q;
  aat_pkg::coord_t rep_min [aat_pkg::NumAxes];
  aat_pkg::coord_t rep_max [aat_pkg::NumAxes];
  logic            rep_orig;

  function automatic aat_pkg::coord_t saturate(aat_pkg::acc_t v);
    aat_pkg::acc_t sh;
    sh = v >>> aat_pkg::FracW;
    if (sh > aat_pkg::acc_t'(aat_pkg::CoordMax)) begin
      return aat_pkg::CoordMax;
    end else if (sh < aat_pkg::acc_t'(aat_pkg::CoordMin)) begin
      return aat_pkg::CoordMin;
    end
    return sh[aat_pkg::CoordW-1:0];
  endfunction

  assign pt[0]   = in_data_i.point_x;
  assign pt[1]   = in_data_i.point_y;
  assign pt[2]   = in_data_i.point_z;
  assign coef[0] = in_data_i.coef_0;
  assign coef[1] = in_data_i.coef_1;
  assign coef[2] = in_data_i.coef_2;
  assign coef[3] = in_data_i.coef_3;

  // corner bit i picks max or min along axis i
  always_comb begin
    for (int i = 0; i < aat_pkg::NumAxes; i++) begin
      corner[i] = cmd_i.corner_idx[i] ? orig_max_q[i] : orig_min_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < aat_pkg::NumAxes; i++) begin
        cur_min_q[i]  <= aat_pkg::CoordMax;
        cur_max_q[i]  <= aat_pkg::CoordMin;
        orig_min_q[i] <= aat_pkg::CoordMax;
        orig_max_q[i] <= aat_pkg::CoordMin;
      end
      for (int r = 0; r < aat_pkg::NumRows; r++) begin
        for (int c = 0; c < aat_pkg::NumCols; c++) begin
          matrix_q[r][c] <= '0;
        end
      end
      has_orig_q <= 1'b0;
    end else if (cmd_i.accept) begin
      case (aat_pkg::cmd_e'(in_data_i.cmd))
        aat_pkg::CMD_RESET: begin
          for (int i = 0; i < aat_pkg::NumAxes; i++) begin
            cur_min_q[i]  <= aat_pkg::CoordMax;
            cur_max_q[i]  <= aat_pkg::CoordMin;
            orig_min_q[i] <= aat_pkg::CoordMax;
            orig_max_q[i] <= aat_pkg::CoordMin;
          end
          has_orig_q <= 1'b0;
        end
        aat_pkg::CMD_GROW_MIN: begin
          for (int i = 0; i < aat_pkg::NumAxes; i++) begin
            if (pt[i] < cur_min_q[i]) begin
              cur_min_q[i] <= pt[i];
            end
          end
        end
        aat_pkg::CMD_GROW_MAX: begin
          for (int i = 0; i < aat_pkg::NumAxes; i++) begin
            if (pt[i] > cur_max_q[i]) begin
              cur_max_q[i] <= pt[i];
            end
          end
        end
        aat_pkg::CMD_LOAD_ROW: begin
          // a row index past the last row writes nothing
          if (in_data_i.row_index < aat_pkg::RowW'(aat_pkg::NumRows)) begin
            for (int c = 0; c < aat_pkg::NumCols; c++) begin
              matrix_q[in_data_i.row_index[aat_pkg::RowW-1:0]][c] <= coef[c];
            end
          end
        end
        aat_pkg::CMD_TRANSFORM: begin
          if (!has_orig_q) begin
            for (int i = 0; i < aat_pkg::NumAxes; i++) begin
              orig_min_q[i] <= cur_min_q[i];
              orig_max_q[i] <= cur_max_q[i];
            end
            has_orig_q <= 1'b1;
          end
          for (int i = 0; i < aat_pkg::NumAxes; i++) begin
            cur_min_q[i] <= aat_pkg::CoordMax;
            cur_max_q[i] <= aat_pkg::CoordMin;
          end
        end
        default: begin
        end
      endcase
    end else if (v_vld_q) begin
      // grow the current box by one mapped corner
      for (int r = 0; r < aat_pkg::NumRows; r++) begin
        if (sat_q[r] < cur_min_q[r]) begin
          cur_min_q[r] <= sat_q[r];
        end
        if (sat_q[r] > cur_max_q[r]) begin
          cur_max_q[r] <= sat_q[r];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
      v_vld_q <= 1'b0;
    end else begin
      p_vld_q <= cmd_i.corner_en;
      s_vld_q <= p_vld_q;
      v_vld_q <= s_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= in_data_i.cmd;
    end
    if (cmd_i.corner_en) begin
      for (int r = 0; r < aat_pkg::NumRows; r++) begin
        for (int i = 0; i < aat_pkg::NumAxes; i++) begin
          prod_q[r][i] <= aat_pkg::prod_t'(matrix_q[r][i]) * aat_pkg::prod_t'(corner[i]);
        end
        tr_q[r] <= matrix_q[r][aat_pkg::NumCols-1];
      end
    end
    if (p_vld_q) begin
      for (int r = 0; r < aat_pkg::NumRows; r++) begin
        sum_q[r] <= aat_pkg::acc_t'(prod_q[r][0]) + aat_pkg::acc_t'(prod_q[r][1])
                  + aat_pkg::acc_t'(prod_q[r][2])
                  + (aat_pkg::acc_t'(tr_q[r]) <<< aat_pkg::FracW);
      end
    end
    if (s_vld_q) begin
      for (int r = 0; r < aat_pkg::NumRows; r++) begin
        sat_q[r] <= saturate(sum_q[r]);
      end
    end
    if (cmd_i.emit) begin
      out_q.min_x    <= rep_min[0];
      out_q.min_y    <= rep_min[1];
      out_q.min_z    <= rep_min[2];
      out_q.max_x    <= rep_max[0];
      out_q.max_y    <= rep_max[1];
      out_q.max_z    <= rep_max[2];
      out_q.center_x <= aat_pkg::half_sum(rep_max[0], rep_min[0]);
      out_q.center_y <= aat_pkg::half_sum(rep_max[1], rep_min[1]);
      out_q.center_z <= aat_pkg::half_sum(rep_max[2], rep_min[2]);
      out_q.half_x   <= aat_pkg::half_diff(rep_max[0], rep_min[0]);
      out_q.half_y   <= aat_pkg::half_diff(rep_max[1], rep_min[1]);
      out_q.half_z   <= aat_pkg::half_diff(rep_max[2], rep_min[2]);
    end
  end

  assign rep_orig = (cmd_q == aat_pkg::CMD_REPORT) && has_orig_q;

  always_comb begin
    for (int i = 0; i < aat_pkg::NumAxes; i++) begin
      rep_min[i] = rep_orig ? orig_min_q[i] : cur_min_q[i];
      rep_max[i] = rep_orig ? orig_max_q[i] : cur_max_q[i];
    end
  end

  assign stat_o.pipe_busy = p_vld_q || s_vld_q || v_vld_q;
  assign out_data_o       = out_q;

endmodule

// ===== rtl/core/aabb_accumulate_transform.sv =====
// Top level of the axis-aligned box accumulate and transform block.
// Result path: a plain command goes straight to the output load; a transform first
// makes eight corner passes through the shared three-row multiply unit, then
// its three pipeline stages, a drain check and the output load.
// Throughput: one input at a time; the next input is taken once the result is loaded.
// Reset (async, active low): boxes empty, no original, matrix zero, pipeline idle.
`include "assert_macros.svh"

module aabb_accumulate_transform (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  aat_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output aat_pkg::out_t out_data_o
);

  aat_pkg::ctrl_cmd_t ctrl_cmd;
  aat_pkg::dp_stat_t  dp_stat;

  // Sequencer: takes one transfer at a time, issues the eight corners of a
  // transform, waits for the multiply pipeline to drain, then loads the
  // output register. The output register lets the next transfer in while a
  // result still waits downstream.
  aat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  // Datapath: box and matrix registers, per-corner products of all three rows
  // in parallel, wide sum with translation, floor shift with saturation, and
  // min/max accumulation into the current box.
  aat_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (ctrl_cmd),
    .stat_o     (dp_stat),
    .out_data_o (out_data_o)
  );

  // One item at a time: a transfer always closes the input for the next cycle.
  `ASSERT_CLK(a_single_item, (in_valid_i && !in_stall_o) |=> in_stall_o, "input taken twice in a row")
  // Never load a result while mapped corners are still in flight.
  `ASSERT_NEVER(a_emit_drained, ctrl_cmd.emit && dp_stat.pipe_busy, "result loaded before drain")
  // Never take a new command while the pipeline still updates the box.
  `ASSERT_NEVER(a_accept_drained, ctrl_cmd.accept && dp_stat.pipe_busy, "command taken while busy")

endmodule
